// ----- rtl/core/owtr_pkg.sv -----
// Shared types, constants and the CRC step for the one-wire temperature sensor reader.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package owtr_pkg;

  // Widths of the configuration port.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_RESET_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESENCE_WAIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RESET_RECOVER = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SLOT_START    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_HOLD    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_READ_SAMPLE   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SLOT_RECOVER  = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_BYTE_GAP      = 3'd7;

  // Bus commands.
  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;
  localparam logic [7:0] CMD_CONVERT      = 8'h44;

  // Feedback term of the reflected CRC-8 step.
  localparam logic [7:0] CRC_FEEDBACK = 8'h18;

  typedef struct packed {
    logic [9:0] reset_low_ticks;
    logic [7:0] presence_wait_ticks;
    logic [9:0] reset_recover_ticks;
    logic [5:0] slot_start_ticks;
    logic [7:0] write_hold_ticks;
    logic [5:0] read_sample_ticks;
    logic [5:0] slot_recover_ticks;
    logic [5:0] byte_gap_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET_VALUE = '{
    reset_low_ticks:     10'd700,
    presence_wait_ticks: 8'd35,
    reset_recover_ticks: 10'd640,
    slot_start_ticks:    6'd5,
    write_hold_ticks:    8'd30,
    read_sample_ticks:   6'd10,
    slot_recover_ticks:  6'd5,
    byte_gap_ticks:      6'd10
  };

  typedef struct packed {
    logic start_req;
    logic line_level;
  } req_t;

  typedef struct packed {
    logic               pull_low;
    logic               busy_res;
    logic               done_res;
    logic               crc_ok;
    logic               presence_seen;
    logic signed [15:0] temperature;
  } res_t;

  // One byte of the Maxim CRC-8, starting from a zero register.
  function automatic logic [7:0] crc8_byte(logic [7:0] v);
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] x;
    c = 8'h00;
    d = v;
    for (int i = 0; i < 8; i++) begin
      x = c ^ CRC_FEEDBACK;
      if ((c[0] ^ d[0]) == 1'b1) begin
        c = {1'b1, x[7:1]};
      end else begin
        c = {1'b0, c[7:1]};
      end
      d = {1'b0, d[7:1]};
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/owtr_seq.sv -----
// Bus sequencer: phase, timing counter, shift register, scratchpad and CRC state.
// Advances one tick per accepted request. Depends on owtr_pkg.
module owtr_seq #(
  parameter int unsigned SCRATCH_BYTES     = 9,
  parameter int unsigned CRC_COVERED_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  owtr_pkg::req_t req_i,
  input  owtr_pkg::cfg_t cfg_i,
  output owtr_pkg::res_t res_o
);

  localparam int unsigned ByteW = $clog2(SCRATCH_BYTES + 1);
  localparam int unsigned SpW   = $clog2(SCRATCH_BYTES);
  localparam logic [SpW-1:0] CrcIdx = SpW'(CRC_COVERED_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_R1_LOW  = 4'd1,
    PH_R1_WAIT = 4'd2,
    PH_R1_REC  = 4'd3,
    PH_WA_SLOT = 4'd4,
    PH_WA_GAP  = 4'd5,
    PH_RD_SLOT = 4'd6,
    PH_R2_LOW  = 4'd7,
    PH_R2_WAIT = 4'd8,
    PH_R2_REC  = 4'd9,
    PH_WB_SLOT = 4'd10,
    PH_WB_GAP  = 4'd11
  } phase_e;

  // True on the last tick of a segment; a zero length still lasts one tick.
  function automatic logic seg_last(logic [9:0] t, logic [10:0] len);
    logic [10:0] l;
    l = (len == 11'd0) ? 11'd1 : len;
    return (11'(t) + 11'd1) >= l;
  endfunction

  phase_e            phase_q, phase_d;
  logic [9:0]        tick_q, tick_d;
  logic [2:0]        bit_q, bit_d;
  logic [ByteW-1:0]  byte_q, byte_d;
  logic [7:0]        shift_q, shift_d;
  logic [7:0]        crc_q, crc_d;
  logic [15:0]       temp_q, temp_d;
  logic [1:0]        flags_q, flags_d;
  logic [7:0]        sp_q [SCRATCH_BYTES];

  logic              pull;
  logic              done;
  logic              sp_we;
  logic [7:0]        shift_new;
  logic [ByteW-1:0]  byte_inc;
  logic [10:0]       t_ext;
  logic [10:0]       wr_len;
  logic [10:0]       rd_samp;
  logic [10:0]       rd_end;
  logic              crc_match;

  assign t_ext     = 11'(tick_q);
  assign wr_len    = 11'(cfg_i.slot_start_ticks) + 11'(cfg_i.write_hold_ticks)
                   + 11'(cfg_i.slot_recover_ticks);
  assign rd_samp   = 11'(cfg_i.slot_start_ticks) + 11'(cfg_i.read_sample_ticks);
  assign rd_end    = rd_samp + 11'(cfg_i.slot_recover_ticks);
  assign byte_inc  = byte_q + ByteW'(1);
  assign crc_match = (crc_q == sp_q[CrcIdx]);

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    shift_d   = shift_q;
    crc_d     = crc_q;
    temp_d    = temp_q;
    flags_d   = flags_q;
    pull      = 1'b0;
    done      = 1'b0;
    sp_we     = 1'b0;
    shift_new = shift_q;

    case (phase_q)
      PH_IDLE: begin
        if (req_i.start_req) begin
          phase_d = PH_R1_LOW;
          tick_d  = '0;
          bit_d   = '0;
          byte_d  = '0;
          crc_d   = '0;
        end
      end
      PH_R1_LOW, PH_R2_LOW: begin
        pull = 1'b1;
        if (seg_last(tick_q, 11'(cfg_i.reset_low_ticks))) begin
          tick_d  = '0;
          phase_d = (phase_q == PH_R1_LOW) ? PH_R1_WAIT : PH_R2_WAIT;
        end else begin
          tick_d = tick_q + 10'd1;
        end
      end
      PH_R1_WAIT, PH_R2_WAIT: begin
        if (tick_q >= 10'(cfg_i.presence_wait_ticks)) begin
          flags_d[1] = ~req_i.line_level;
          tick_d     = '0;
          phase_d    = (phase_q == PH_R1_WAIT) ? PH_R1_REC : PH_R2_REC;
        end else begin
          tick_d = tick_q + 10'd1;
        end
      end
      PH_R1_REC, PH_R2_REC: begin
        if (seg_last(tick_q, 11'(cfg_i.reset_recover_ticks))) begin
          tick_d  = '0;
          phase_d = (phase_q == PH_R1_REC) ? PH_WA_SLOT : PH_WB_SLOT;
          byte_d  = '0;
          bit_d   = '0;
          shift_d = owtr_pkg::CMD_SKIP_ROM;
        end else begin
          tick_d = tick_q + 10'd1;
        end
      end
      PH_WA_SLOT, PH_WB_SLOT: begin
        // Low for the slot opening, then held low only while sending a zero.
        pull = (t_ext < 11'(cfg_i.slot_start_ticks)) ||
               ((t_ext < 11'(cfg_i.slot_start_ticks) + 11'(cfg_i.write_hold_ticks)) &&
                !shift_q[0]);
        if (seg_last(tick_q, wr_len)) begin
          tick_d  = '0;
          shift_d = {1'b0, shift_q[7:1]};
          if (bit_q == 3'd7) begin
            bit_d   = '0;
            phase_d = (phase_q == PH_WA_SLOT) ? PH_WA_GAP : PH_WB_GAP;
          end else begin
            bit_d = bit_q + 3'd1;
          end
        end else begin
          tick_d = tick_q + 10'd1;
        end
      end
      PH_WA_GAP, PH_WB_GAP: begin
        if (seg_last(tick_q, 11'(cfg_i.byte_gap_ticks))) begin
          tick_d = '0;
          if (byte_q == '0) begin
            byte_d  = ByteW'(1);
            shift_d = (phase_q == PH_WA_GAP) ? owtr_pkg::CMD_READ_SCRATCH
                                             : owtr_pkg::CMD_CONVERT;
            phase_d = (phase_q == PH_WA_GAP) ? PH_WA_SLOT : PH_WB_SLOT;
          end else if (phase_q == PH_WA_GAP) begin
            byte_d  = '0;
            shift_d = '0;
            crc_d   = '0;
            phase_d = PH_RD_SLOT;
          end else begin
            byte_d     = '0;
            phase_d    = PH_IDLE;
            done       = 1'b1;
            flags_d[0] = crc_match;
            if (crc_match) begin
              temp_d = {sp_q[1], sp_q[0]};
            end
          end
        end else begin
          tick_d = tick_q + 10'd1;
        end
      end
      PH_RD_SLOT: begin
        pull = (t_ext < 11'(cfg_i.slot_start_ticks));
        if (t_ext == rd_samp) begin
          shift_new = {req_i.line_level, shift_q[7:1]};
        end
        shift_d = shift_new;
        if (t_ext >= rd_end) begin
          tick_d = '0;
          if (bit_q == 3'd7) begin
            bit_d = '0;
            sp_we = 1'b1;
            if (32'(byte_q) < CRC_COVERED_BYTES) begin
              crc_d = owtr_pkg::crc8_byte(crc_q ^ shift_new);
            end
            if (32'(byte_inc) >= SCRATCH_BYTES) begin
              byte_d  = '0;
              phase_d = PH_R2_LOW;
            end else begin
              byte_d = byte_inc;
            end
          end else begin
            bit_d = bit_q + 3'd1;
          end
        end else begin
          tick_d = tick_q + 10'd1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  always_comb begin
    res_o.pull_low      = pull;
    res_o.busy_res      = (phase_d != PH_IDLE) || done;
    res_o.done_res      = done;
    res_o.crc_ok        = flags_d[0];
    res_o.presence_seen = flags_d[1];
    res_o.temperature   = $signed(temp_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      shift_q <= '0;
      crc_q   <= '0;
      temp_q  <= '0;
      flags_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      shift_q <= shift_d;
      crc_q   <= crc_d;
      temp_q  <= temp_d;
      flags_q <= flags_d;
    end
  end

  // Scratchpad bytes carry no reset; each is written before it is used.
  always_ff @(posedge clk_i) begin
    if (fire_i && sp_we) begin
      sp_q[byte_q[SpW-1:0]] <= shift_new;
    end
  end

endmodule

// ----- rtl/core/owtr_obuf.sv -----
// Result register with a skid entry, so a new tick is taken while one result waits.
// Depends on owtr_pkg for the result type.
module owtr_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           fire_o,
  input  owtr_pkg::res_t res_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output owtr_pkg::res_t out_res_o
);

  logic           ov_q, ov_d;
  logic           sv_q, sv_d;
  owtr_pkg::res_t od_q, od_d;
  owtr_pkg::res_t sd_q, sd_d;
  logic           fire;

  assign fire        = in_valid_i && !sv_q;
  assign fire_o      = fire;
  assign in_stall_o  = sv_q;
  assign out_valid_o = ov_q;
  assign out_res_o   = od_q;

  always_comb begin
    ov_d = ov_q;
    sv_d = sv_q;
    od_d = od_q;
    sd_d = sd_q;
    if (!ov_q || !out_stall_i) begin
      // Output slot frees up: the skid entry goes first, otherwise the new result.
      ov_d = sv_q || fire;
      od_d = sv_q ? sd_q : res_i;
      sv_d = 1'b0;
    end else if (fire) begin
      sv_d = 1'b1;
      sd_d = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
      sv_q <= sv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
    sd_q <= sd_d;
  end

endmodule

// ----- rtl/core/onewire_temp_sensor_reader.sv -----
// Top level of the one-wire temperature sensor reader: configuration registers,
// sequencer and result buffer. Depends on owtr_pkg, owtr_seq and owtr_obuf.
//
// Each request is one microsecond bus tick carrying a start flag and the sampled line
// level; each request yields exactly one result, in order, giving the drive level for
// the line, busy/done flags, the CRC and presence status and the last good temperature
// in 1/16 degree units. A request is taken every clock cycle unless the input is
// stalled; its result is registered in the output or skid entry. The tick update is one
// pass through the sequencer logic, so input stalls come only from the result side: the
// input is held off only while two results are waiting. A start runs reset, skip-ROM,
// read-scratchpad, a nine byte read, a second reset, skip-ROM and convert; a bad CRC
// keeps the previous reading. The user must write the timing registers through the
// plain write port only while no sequence is in progress; the block does not enforce it.
module onewire_temp_sensor_reader #(
  parameter int unsigned SCRATCH_BYTES     = 9,
  parameter int unsigned CRC_COVERED_BYTES = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  owtr_pkg::req_t                    in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output owtr_pkg::res_t                    out_res_o,
  input  logic                              cfg_we_i,
  input  logic [owtr_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [owtr_pkg::CfgDataW-1:0]     cfg_data_i
);

  owtr_pkg::cfg_t cfg_q;
  owtr_pkg::res_t seq_res;
  logic           fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= owtr_pkg::CFG_RESET_VALUE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        owtr_pkg::CFG_RESET_LOW:     cfg_q.reset_low_ticks     <= cfg_data_i;
        owtr_pkg::CFG_PRESENCE_WAIT: cfg_q.presence_wait_ticks <= cfg_data_i[7:0];
        owtr_pkg::CFG_RESET_RECOVER: cfg_q.reset_recover_ticks <= cfg_data_i;
        owtr_pkg::CFG_SLOT_START:    cfg_q.slot_start_ticks    <= cfg_data_i[5:0];
        owtr_pkg::CFG_WRITE_HOLD:    cfg_q.write_hold_ticks    <= cfg_data_i[7:0];
        owtr_pkg::CFG_READ_SAMPLE:   cfg_q.read_sample_ticks   <= cfg_data_i[5:0];
        owtr_pkg::CFG_SLOT_RECOVER:  cfg_q.slot_recover_ticks  <= cfg_data_i[5:0];
        owtr_pkg::CFG_BYTE_GAP:      cfg_q.byte_gap_ticks      <= cfg_data_i[5:0];
        default:                     cfg_q                     <= cfg_q;
      endcase
    end
  end

  owtr_seq #(
    .SCRATCH_BYTES    (SCRATCH_BYTES),
    .CRC_COVERED_BYTES(CRC_COVERED_BYTES)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .req_i (in_req_i),
    .cfg_i (cfg_q),
    .res_o (seq_res)
  );

  owtr_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .fire_o     (fire),
    .res_i      (seq_res),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_res_o  (out_res_o)
  );

endmodule

// ----- rtl/core/owtr_checker.sv -----
// Port-level checks for the one-wire temperature sensor reader, bound to its top level.
// Depends on owtr_pkg and onewire_temp_sensor_reader.
module owtr_assert (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input owtr_pkg::res_t out_res_o
);

  a_out_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_res_o))
    else $error("stalled result changed");

  a_done_is_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.done_res |-> out_res_o.busy_res)
    else $error("completion reported without busy");

  a_idle_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.busy_res |-> !out_res_o.pull_low)
    else $error("bus driven low while idle");

  // Input is held off only when a result is already waiting under stall.
  a_stall_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_stall_i))
    else $error("input stalled without a result backlog");

endmodule

bind onewire_temp_sensor_reader owtr_assert u_owtr_assert (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_res_o  (out_res_o)
);
